### hw/rtl/fpgs_pkg.sv
`default_nettype none

package fpgs_pkg;

    localparam int CNT_W = 9;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PASS_COUNT  = 2'd2;

    // floor(n/5) == (n * DIV5_MULT) >> DIV5_SHIFT for n < 2**18
    localparam logic [15:0] DIV5_MULT  = 16'd52429;
    localparam int          DIV5_SHIFT = 18;

    typedef struct packed {
        logic             acc;
        logic             grid_rd;
        logic             lb_rd;
        logic             cell_wr;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
        logic             cap_left;
        logic             cap_mid;
        logic             cap_right;
        logic             cap_down;
        logic             sum_en;
        logic             up_sel_grid;
        logic             mul_en;
        logic             resp_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

### hw/rtl/fpgs_ram.sv
`default_nettype none

module fpgs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/fpgs_ctrl.sv
`default_nettype none

module fpgs_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [1:0]                   i_opcode,
    input  wire logic [fpgs_pkg::CNT_W-1:0]   i_eff_w,
    input  wire logic [fpgs_pkg::CNT_W-1:0]   i_eff_h,
    input  wire logic [7:0]                   i_pass_count,
    input  wire fpgs_pkg::t_dp_sts            i_sts,
    output fpgs_pkg::t_dp_cmd                 o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RESP  = 4'd1;
    localparam logic [3:0] S_LD_L  = 4'd2;
    localparam logic [3:0] S_LD_M  = 4'd3;
    localparam logic [3:0] S_CAP_M = 4'd4;
    localparam logic [3:0] S_RD_R  = 4'd5;
    localparam logic [3:0] S_RD_D  = 4'd6;
    localparam logic [3:0] S_RD_U  = 4'd7;
    localparam logic [3:0] S_SUM   = 4'd8;
    localparam logic [3:0] S_MUL   = 4'd9;
    localparam logic [3:0] S_WR    = 4'd10;

    logic [3:0]                 r_state, n_state;
    logic [fpgs_pkg::CNT_W-1:0] r_row, n_row;
    logic [fpgs_pkg::CNT_W-1:0] r_col, n_col;
    logic [7:0]                 r_pass, n_pass;
    logic                       can_take;
    logic                       accept;
    logic                       skip_run;
    logic                       col_last;
    logic                       row_last;
    logic                       pass_last;

    assign can_take   = (r_state == S_IDLE) || ((r_state == S_RESP) && i_sts.out_free);
    assign o_in_stall = !can_take;
    assign accept     = i_in_valid && can_take;
    assign skip_run   = (i_pass_count == 8'd0) || (i_eff_w < 9'd3) || (i_eff_h < 9'd3);
    assign col_last   = (r_col == i_eff_w - 9'd2);
    assign row_last   = (r_row == i_eff_h - 9'd2);
    assign pass_last  = (r_pass == i_pass_count - 8'd1);

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_pass  = r_pass;
        o_cmd   = '0;
        o_cmd.acc = accept;
        o_cmd.row = r_row;
        o_cmd.col = r_col;
        unique case (r_state) inside
            S_IDLE, S_RESP: begin
                o_cmd.resp_load = (r_state == S_RESP) && i_sts.out_free;
                if (accept) begin
                    if ((i_opcode == fpgs_pkg::OP_RUN) && !skip_run) begin
                        n_state = S_LD_L;
                        n_row   = 9'd1;
                        n_col   = 9'd1;
                        n_pass  = 8'd0;
                    end else begin
                        n_state = S_RESP;
                    end
                end else if ((r_state == S_RESP) && i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_LD_L: begin
                o_cmd.grid_rd = 1'b1;
                o_cmd.col     = 9'd0;
                n_state       = S_LD_M;
            end
            S_LD_M: begin
                o_cmd.cap_left = 1'b1;
                o_cmd.grid_rd  = 1'b1;
                o_cmd.col      = 9'd1;
                n_state        = S_CAP_M;
            end
            S_CAP_M: begin
                o_cmd.cap_mid = 1'b1;
                n_state       = S_RD_R;
            end
            S_RD_R: begin
                o_cmd.grid_rd = 1'b1;
                o_cmd.col     = r_col + 9'd1;
                n_state       = S_RD_D;
            end
            S_RD_D: begin
                o_cmd.cap_right = 1'b1;
                o_cmd.grid_rd   = 1'b1;
                o_cmd.lb_rd     = 1'b1;
                o_cmd.row       = r_row + 9'd1;
                n_state         = S_RD_U;
            end
            S_RD_U: begin
                o_cmd.cap_down = 1'b1;
                o_cmd.grid_rd  = 1'b1;
                o_cmd.row      = r_row - 9'd1;
                n_state        = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_en      = 1'b1;
                o_cmd.up_sel_grid = (r_row == 9'd1);
                n_state           = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_WR;
            end
            S_WR: begin
                o_cmd.cell_wr = 1'b1;
                if (!col_last) begin
                    n_col   = r_col + 9'd1;
                    n_state = S_RD_R;
                end else begin
                    n_col = 9'd1;
                    if (!row_last) begin
                        n_row   = r_row + 9'd1;
                        n_state = S_LD_L;
                    end else if (!pass_last) begin
                        n_row   = 9'd1;
                        n_pass  = r_pass + 8'd1;
                        n_state = S_LD_L;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_pass  <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_pass  <= n_pass;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/fpgs_dpath.sv
`default_nettype none

module fpgs_dpath #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire fpgs_pkg::t_dp_cmd           i_cmd,
    output fpgs_pkg::t_dp_sts                o_sts,
    input  wire logic [fpgs_pkg::CNT_W-1:0]  i_eff_w,
    input  wire logic [fpgs_pkg::CNT_W-1:0]  i_eff_h,
    input  wire logic [1:0]                  i_opcode,
    input  wire logic [7:0]                  i_column,
    input  wire logic [7:0]                  i_row,
    input  wire logic signed [15:0]          i_sample_in,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [1:0]                       o_answered_opcode,
    output logic signed [15:0]               o_sample_out
);

    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW = CW + RW;

    logic [CW-1:0]        a_col;
    logic [RW-1:0]        a_row;
    logic                 in_grid;
    logic                 grid_we;
    logic                 grid_re;
    logic [15:0]          grid_wdata;
    logic [15:0]          grid_rdata;
    logic [15:0]          lb_rdata;
    logic signed [15:0]   up_val;
    logic signed [18:0]   n_sum;
    logic [18:0]          sum_mag;
    logic [33:0]          n_prod;
    logic [15:0]          quot;
    logic [15:0]          cell_val;

    logic [1:0]           r_op;
    logic                 r_inside;
    logic signed [15:0]   r_left;
    logic signed [15:0]   r_mid;
    logic signed [15:0]   r_right;
    logic signed [15:0]   r_down;
    logic signed [18:0]   r_sum;
    logic [33:0]          r_prod;
    logic                 r_neg;

    assign in_grid = ({1'b0, i_column} < i_eff_w) && ({1'b0, i_row} < i_eff_h);
    assign a_col   = i_cmd.acc ? CW'(i_column) : CW'(i_cmd.col);
    assign a_row   = i_cmd.acc ? RW'(i_row) : RW'(i_cmd.row);

    assign grid_we = (i_cmd.acc && (i_opcode == fpgs_pkg::OP_WRITE) && in_grid)
                   || i_cmd.cell_wr;
    assign grid_re = (i_cmd.acc && (i_opcode == fpgs_pkg::OP_READ)) || i_cmd.grid_rd;

    assign sum_mag  = r_sum[18] ? 19'(-r_sum) : 19'(r_sum);
    assign n_prod   = 34'(sum_mag[17:0]) * 34'(fpgs_pkg::DIV5_MULT);
    assign quot     = r_prod[fpgs_pkg::DIV5_SHIFT +: 16];
    assign cell_val = r_neg ? 16'(-quot) : quot;
    assign grid_wdata = i_cmd.acc ? i_sample_in : cell_val;

    assign up_val = i_cmd.up_sel_grid ? grid_rdata : lb_rdata;
    assign n_sum  = 19'(r_left) + 19'(r_mid) + 19'(r_right) + 19'(r_down) + 19'(up_val);

    fpgs_ram #(
        .WIDTH (16),
        .DEPTH (2 ** AW)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (grid_we),
        .i_waddr ({a_row, a_col}),
        .i_wdata (grid_wdata),
        .i_re    (grid_re),
        .i_raddr ({a_row, a_col}),
        .o_rdata (grid_rdata)
    );

    // pre-pass copy of the row above, interior columns only
    fpgs_ram #(
        .WIDTH (16),
        .DEPTH (2 ** CW)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (i_cmd.cell_wr),
        .i_waddr (CW'(i_cmd.col)),
        .i_wdata (r_mid),
        .i_re    (i_cmd.lb_rd),
        .i_raddr (CW'(i_cmd.col)),
        .o_rdata (lb_rdata)
    );

    assign o_sts.out_free = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_op     <= i_opcode;
            r_inside <= in_grid;
        end
        if (i_cmd.cap_left) begin
            r_left <= grid_rdata;
        end
        if (i_cmd.cap_mid) begin
            r_mid <= grid_rdata;
        end
        if (i_cmd.cap_right) begin
            r_right <= grid_rdata;
        end
        if (i_cmd.cap_down) begin
            r_down <= grid_rdata;
        end
        if (i_cmd.cell_wr) begin
            r_left <= r_mid;
            r_mid  <= r_right;
        end
        if (i_cmd.sum_en) begin
            r_sum <= n_sum;
        end
        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
            r_neg  <= r_sum[18];
        end
        if (i_cmd.resp_load) begin
            o_answered_opcode <= r_op;
            o_sample_out      <= ((r_op == fpgs_pkg::OP_READ) && r_inside) ? grid_rdata : 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.resp_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/five_point_grid_smoother.sv
// Grid of signed 16-bit heights with a five-point smoother. Write and read
// items can follow one another back to back when the result side keeps up;
// a read returns 0 for a point outside the configured width and height, and
// writes there are dropped. A run item walks every interior cell of the grid
// for each pass, loading the left and middle cells at the start of each row.
// Each cell needs three reads from the single read port of the grid RAM
// (right, lower and upper neighbours), then the sum, the multiply by the
// reciprocal of five and the write, one after the other. Cells never written
// read back undefined. Configuration writes belong between items, with no
// result outstanding.
`default_nettype none

module five_point_grid_smoother #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [8:0]         i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_opcode,
    input  wire logic [7:0]         i_column,
    input  wire logic [7:0]         i_row,
    input  wire logic signed [15:0] i_sample_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_answered_opcode,
    output logic signed [15:0]      o_sample_out
);

    localparam logic [8:0] MAX_W = (MAX_COLUMNS > 511) ? 9'd511 : 9'(MAX_COLUMNS);
    localparam logic [8:0] MAX_H = (MAX_ROWS > 511) ? 9'd511 : 9'(MAX_ROWS);

    logic [8:0]        r_grid_width;
    logic [8:0]        r_grid_height;
    logic [7:0]        r_pass_count;
    logic [8:0]        eff_w;
    logic [8:0]        eff_h;
    fpgs_pkg::t_dp_cmd cmd;
    fpgs_pkg::t_dp_sts sts;

    assign eff_w = (r_grid_width > MAX_W) ? MAX_W : r_grid_width;
    assign eff_h = (r_grid_height > MAX_H) ? MAX_H : r_grid_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= 9'd256;
            r_grid_height <= 9'd256;
            r_pass_count  <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fpgs_pkg::REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                fpgs_pkg::REG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                fpgs_pkg::REG_PASS_COUNT:  r_pass_count  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    fpgs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_eff_w      (eff_w),
        .i_eff_h      (eff_h),
        .i_pass_count (r_pass_count),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    fpgs_dpath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_eff_w           (eff_w),
        .i_eff_h           (eff_h),
        .i_opcode          (i_opcode),
        .i_column          (i_column),
        .i_row             (i_row),
        .i_sample_in       (i_sample_in),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_answered_opcode (o_answered_opcode),
        .o_sample_out      (o_sample_out)
    );

endmodule

`default_nettype wire
